@@ hw/rtl/rraf_pkg.sv @@
// Shared types and constants for the rounded rectangle alpha fill block.
package rraf_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_RECT_LEFT   = 3'd0;
    localparam logic [2:0] CFG_RECT_TOP    = 3'd1;
    localparam logic [2:0] CFG_RECT_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_RECT_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_RADIUS      = 3'd4;
    localparam logic [2:0] CFG_FILL_COLOR  = 3'd5;
    localparam logic [2:0] CFG_BLEND_ALPHA = 3'd6;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [11:0] rect_left;
        logic [11:0] rect_top;
        logic [10:0] rect_width;
        logic [10:0] rect_height;
        logic [7:0]  corner_radius;
        logic [31:0] fill_color;
        logic [7:0]  blend_alpha;
    } t_cfg;

endpackage

@@ hw/rtl/rraf_cfg_regs.sv @@
// Configuration register file for the rounded rectangle alpha fill block.
module rraf_cfg_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output rraf_pkg::t_cfg     o_cfg
);

    rraf_pkg::t_cfg r_cfg;
    rraf_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rraf_pkg::CFG_RECT_LEFT:   n_cfg.rect_left     = i_cfg_data[11:0];
                rraf_pkg::CFG_RECT_TOP:    n_cfg.rect_top      = i_cfg_data[11:0];
                rraf_pkg::CFG_RECT_WIDTH:  n_cfg.rect_width    = i_cfg_data[10:0];
                rraf_pkg::CFG_RECT_HEIGHT: n_cfg.rect_height   = i_cfg_data[10:0];
                rraf_pkg::CFG_RADIUS:      n_cfg.corner_radius = i_cfg_data[7:0];
                rraf_pkg::CFG_FILL_COLOR:  n_cfg.fill_color    = i_cfg_data;
                rraf_pkg::CFG_BLEND_ALPHA: n_cfg.blend_alpha   = i_cfg_data[7:0];
                default:                   n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rect_left:     12'd0,
                       rect_top:      12'd0,
                       rect_width:    11'd0,
                       rect_height:   11'd0,
                       corner_radius: 8'd0,
                       fill_color:    32'd0,
                       blend_alpha:   rraf_pkg::ALPHA_OPAQUE};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/rraf_cover.sv @@
// Coverage test: pixel inside the screen-clipped rounded rectangle.
module rraf_cover #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic [9:0]     i_px,
    input  logic [9:0]     i_py,
    input  rraf_pkg::t_cfg i_cfg,
    output logic           o_covered
);

    localparam logic [11:0] SCR_W = 12'(SCREEN_WIDTH);
    localparam logic [11:0] SCR_H = 12'(SCREEN_HEIGHT);

    logic        on_screen;
    logic [12:0] u, v;
    logic        in_x, in_y;
    logic [10:0] uu, vv;
    logic [7:0]  r1, r2;
    logic        in_left, in_right, in_top, in_bot;
    logic [10:0] dist_r, dist_b;
    logic [7:0]  ix, iy, dx, dy;
    logic [15:0] dx2, dy2, rr;
    logic [16:0] dsq;
    logic        corner, in_arc;

    always_comb begin
        on_screen = ({2'b00, i_px} < SCR_W) && ({2'b00, i_py} < SCR_H);

        // Position relative to the rectangle origin, 13-bit two's complement
        u = {3'b000, i_px} - {i_cfg.rect_left[11], i_cfg.rect_left};
        v = {3'b000, i_py} - {i_cfg.rect_top[11], i_cfg.rect_top};
        in_x = !u[12] && (u[11:0] < {1'b0, i_cfg.rect_width});
        in_y = !v[12] && (v[11:0] < {1'b0, i_cfg.rect_height});
        uu = u[10:0];
        vv = v[10:0];

        // Clamp radius to half of width, then half of height
        r1 = ({1'b0, i_cfg.rect_width} < {3'b000, i_cfg.corner_radius, 1'b0})
            ? i_cfg.rect_width[8:1] : i_cfg.corner_radius;
        r2 = ({1'b0, i_cfg.rect_height} < {3'b000, r1, 1'b0})
            ? i_cfg.rect_height[8:1] : r1;

        in_left  = uu < {3'b000, r2};
        in_right = uu >= (i_cfg.rect_width - {3'b000, r2});
        in_top   = vv < {3'b000, r2};
        in_bot   = vv >= (i_cfg.rect_height - {3'b000, r2});

        dist_r = i_cfg.rect_width - 11'd1 - uu;
        dist_b = i_cfg.rect_height - 11'd1 - vv;
        ix = in_left ? uu[7:0] : dist_r[7:0];
        iy = in_top  ? vv[7:0] : dist_b[7:0];
        dx = r2 - 8'd1 - ix;
        dy = r2 - 8'd1 - iy;

        dx2    = dx * dx;
        dy2    = dy * dy;
        rr     = r2 * r2;
        dsq    = {1'b0, dx2} + {1'b0, dy2};
        in_arc = dsq <= {1'b0, rr};

        corner = (in_left || in_right) && (in_top || in_bot);

        o_covered = on_screen && in_x && in_y && ((r2 == 8'd0) || !corner || in_arc);
    end

endmodule

@@ hw/rtl/rraf_blend.sv @@
// Per-channel alpha blend of the fill colour over a background pixel.
module rraf_blend (
    input  logic [31:0] i_bg,
    input  logic [31:0] i_fg,
    input  logic [7:0]  i_alpha,
    output logic [31:0] o_color
);

    logic [7:0]  inv_alpha;
    logic [23:0] mixed;

    assign inv_alpha = rraf_pkg::ALPHA_OPAQUE - i_alpha;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [15:0] prod_bg, prod_fg, sum, q;
        always_comb begin
            prod_bg = i_bg[8*c +: 8] * inv_alpha;
            prod_fg = i_fg[8*c +: 8] * i_alpha;
            sum     = prod_bg + prod_fg;
            // floor(sum / 255), exact for sum <= 65025
            q       = sum + 16'd1 + {8'd0, sum[15:8]};
        end
        assign mixed[8*c +: 8] = q[15:8];
    end

    always_comb begin
        if (i_alpha == rraf_pkg::ALPHA_CLEAR) begin
            o_color = i_bg;
        end else if (i_alpha == rraf_pkg::ALPHA_OPAQUE) begin
            o_color = i_fg;
        end else begin
            o_color = {rraf_pkg::ALPHA_OPAQUE, mixed};
        end
    end

endmodule

@@ hw/rtl/rounded_rect_alpha_fill.sv @@
// Rounded rectangle alpha fill: top level with input and result registers.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle, back to back; the input stalls only while both
// registers hold items and the result is stalled.
// Reset (synchronous, active low): clears both valid flags, sets the config registers
// to their defaults (all zero, blend alpha 0xFF). Config port is always ready.
module rounded_rect_alpha_fill #(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [9:0]  i_pixel_x,
    input  logic [9:0]  i_pixel_y,
    input  logic [31:0] i_background,
    // result out
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_new_color,
    output logic        o_covered,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    rraf_pkg::t_cfg cfg;

    // Input stage
    logic        r_s1_vld;
    logic [9:0]  r_px, r_py;
    logic [31:0] r_bg;

    // Result stage
    logic        r_out_vld;
    logic [31:0] r_new_color;
    logic        r_covered;

    logic        out_adv, s1_adv;
    logic        covered;
    logic [31:0] blended;
    logic [31:0] n_new_color;

    assign o_cfg_ready = 1'b1;

    rraf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Pipeline moves whenever the stage ahead is empty or being drained
    assign out_adv = !r_out_vld || !i_stall;
    assign s1_adv  = !r_s1_vld || out_adv;
    assign o_stall = !s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_valid) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
            r_bg <= i_background;
        end
    end

    rraf_cover #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_cover (
        .i_px      (r_px),
        .i_py      (r_py),
        .i_cfg     (cfg),
        .o_covered (covered)
    );

    // Every covered pixel blends over its own background
    rraf_blend u_blend (
        .i_bg    (r_bg),
        .i_fg    (cfg.fill_color),
        .i_alpha (cfg.blend_alpha),
        .o_color (blended)
    );

    assign n_new_color = covered ? blended : r_bg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_vld) begin
            r_new_color <= n_new_color;
            r_covered   <= covered;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_new_color = r_new_color;
    assign o_covered   = r_covered;

endmodule
